FILE: hw/rtl/mrlc_pkg.sv
// Package for the modem reply line classifier.
// Holds shared types, byte codes, verdict codes and reply patterns.
// No dependencies.
package mrlc_pkg;

  localparam int LINE_BYTES_DEF = 64;
  localparam int LEN_MAX_W      = 8;   // holds any line length up to 255 bytes
  localparam int MIN_KEEP       = 7;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  localparam logic [1:0] EXP_JOIN = 2'd1;
  localparam logic [1:0] EXP_SEND = 2'd2;

  typedef enum logic [3:0] {
    V_NONE        = 4'd0,
    V_JOIN_FAILED = 4'd1,
    V_JOINED      = 4'd2,
    V_JOIN_OTHER  = 4'd3,
    V_BUSY        = 4'd4,
    V_NOT_JOINED  = 4'd5,
    V_CONFIRMED   = 4'd6,
    V_PARAM_ERROR = 4'd7,
    V_SEND_OTHER  = 4'd8
  } verdict_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

  // reply patterns, last character in the low byte
  localparam int PLEN_JOIN_FAIL  = 16;
  localparam int PLEN_JOINED     = 11;
  localparam int PLEN_BUSY       = 13;
  localparam int PLEN_NO_NET     = 20;
  localparam int PLEN_CONFIRMED  = 19;
  localparam int PLEN_PARAM      = 14;

  localparam logic [8*PLEN_JOIN_FAIL-1:0] PAT_JOIN_FAIL = "+EVT:JOIN FAILED";
  localparam logic [8*PLEN_JOINED-1:0]    PAT_JOINED    = "+EVT:JOINED";
  localparam logic [8*PLEN_BUSY-1:0]      PAT_BUSY      = {"AT_BUSY", "_ERROR"};
  localparam logic [8*PLEN_NO_NET-1:0]    PAT_NO_NET    = {"AT_NO_NETWORK", "_JOINED"};
  localparam logic [8*PLEN_CONFIRMED-1:0] PAT_CONFIRMED = {"+EVT:SEND", "_CONFIRMED"};
  localparam logic [8*PLEN_PARAM-1:0]     PAT_PARAM     = {"AT_PARAM", "_ERROR"};

  localparam int WIN_BYTES = 20;
  localparam int FILL_W    = $clog2(WIN_BYTES + 1);

  // one queue entry per received byte
  typedef struct packed {
    logic                 job;       // 1: classify the stored line
    logic                 pending;
    logic [LEN_MAX_W-1:0] len;
    logic [1:0]           expected;
  } q_entry_t;

  // back end to front end: line store read port and job completion
  typedef struct packed {
    logic                 rd_en;
    logic [LEN_MAX_W-1:0] rd_addr;
    logic                 job_done;
  } scan_ctl_t;

endpackage

FILE: hw/rtl/mrlc_front.sv
// Front end: accepts bytes, fills the line store, detects CR LF line ends.
// Pushes one queue entry per byte. Depends on mrlc_pkg.
module mrlc_front
  import mrlc_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic [1:0] s_tuser,
  output logic       q_valid,
  input  logic       q_ready,
  output q_entry_t   q_entry,
  input  scan_ctl_t  scan_ctl,
  output logic [7:0] rd_data,
  output logic       busy
);

  localparam int AW = $clog2(LINE_BYTES);

  logic [7:0]    mem [LINE_BYTES];
  logic [AW-1:0] count;
  logic          last_cr;
  logic          accept;
  logic          line_end;
  logic          do_store;
  logic          long_line;

  assign s_tready  = !busy && q_ready;
  assign accept    = s_tvalid && s_tready;
  assign line_end  = (s_tdata == BYTE_LF) && (count != '0) && last_cr;
  assign long_line = count > AW'(MIN_KEEP);
  assign do_store  = !line_end && (count < AW'(LINE_BYTES - 1));
  assign q_valid   = accept;

  always_comb begin
    q_entry.job      = line_end && long_line;
    q_entry.pending  = line_end ? !long_line : do_store;
    q_entry.len      = LEN_MAX_W'(count - AW'(1));
    q_entry.expected = s_tuser;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      last_cr <= 1'b0;
      busy    <= 1'b0;
    end else begin
      if (accept) begin
        if (do_store) begin
          count   <= count + AW'(1);
          last_cr <= (s_tdata == BYTE_CR);
        end else begin
          count <= '0;
        end
        if (line_end && long_line) begin
          busy <= 1'b1;
        end
      end
      if (scan_ctl.job_done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_store) begin
      mem[count] <= s_tdata;
    end
    if (scan_ctl.rd_en) begin
      rd_data <= mem[scan_ctl.rd_addr[AW-1:0]];
    end
  end

endmodule

FILE: hw/rtl/mrlc_fifo.sv
// Two-entry queue between front and back end.
// Depends on mrlc_pkg.
module mrlc_fifo
  import mrlc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  q_entry_t in_entry,
  output logic     out_valid,
  input  logic     out_ready,
  output q_entry_t out_entry
);

  q_entry_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_entry = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_entry;
    end
  end

endmodule

FILE: hw/rtl/mrlc_back.sv
// Back end: scans a finished line one byte a cycle through a 20-byte window,
// matches the reply patterns and drives the result register. Depends on mrlc_pkg.
module mrlc_back
  import mrlc_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  q_entry_t    q_entry,
  output scan_ctl_t   scan_ctl,
  input  logic [7:0]  rd_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata
);

  localparam int AW = $clog2(LINE_BYTES);

  back_state_t            state, state_next;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          len;
  logic [1:0]             expected;
  logic                   stop;
  logic                   rd_valid;
  logic [8*WIN_BYTES-1:0] win;
  logic [8*WIN_BYTES-1:0] win_next;
  logic [FILL_W-1:0]      fill;
  logic [FILL_W-1:0]      fill_next;
  logic [5:0]             found;
  logic [5:0]             hit;
  logic                   take_ok;
  logic                   start;
  logic                   issue_done;
  logic                   out_load;
  logic                   out_pending;
  logic                   out_done;
  verdict_t               out_verdict;
  verdict_t               verdict;
  logic [5:0]             out_length;

  assign take_ok    = !m_tvalid || m_tready;
  assign issue_done = (idx == len) || stop;
  assign win_next   = {win[8*WIN_BYTES-9:0], rd_data};
  assign fill_next  = (fill == FILL_W'(WIN_BYTES)) ? fill : fill + FILL_W'(1);

  assign hit[0] = (fill_next >= FILL_W'(PLEN_JOIN_FAIL)) &&
                  (win_next[8*PLEN_JOIN_FAIL-1:0] == PAT_JOIN_FAIL);
  assign hit[1] = (fill_next >= FILL_W'(PLEN_JOINED)) &&
                  (win_next[8*PLEN_JOINED-1:0] == PAT_JOINED);
  assign hit[2] = (fill_next >= FILL_W'(PLEN_BUSY)) &&
                  (win_next[8*PLEN_BUSY-1:0] == PAT_BUSY);
  assign hit[3] = (fill_next >= FILL_W'(PLEN_NO_NET)) &&
                  (win_next[8*PLEN_NO_NET-1:0] == PAT_NO_NET);
  assign hit[4] = (fill_next >= FILL_W'(PLEN_CONFIRMED)) &&
                  (win_next[8*PLEN_CONFIRMED-1:0] == PAT_CONFIRMED);
  assign hit[5] = (fill_next >= FILL_W'(PLEN_PARAM)) &&
                  (win_next[8*PLEN_PARAM-1:0] == PAT_PARAM);

  always_comb begin
    case (expected)
      EXP_JOIN: verdict = found[0] ? V_JOIN_FAILED :
                          found[1] ? V_JOINED : V_JOIN_OTHER;
      EXP_SEND: verdict = found[2] ? V_BUSY :
                          found[3] ? V_NOT_JOINED :
                          found[4] ? V_CONFIRMED :
                          found[5] ? V_PARAM_ERROR : V_SEND_OTHER;
      default:  verdict = V_NONE;
    endcase
  end

  always_comb begin
    state_next        = state;
    q_ready           = 1'b0;
    start             = 1'b0;
    out_load          = 1'b0;
    out_pending       = 1'b1;
    out_done          = 1'b0;
    out_verdict       = V_NONE;
    out_length        = '0;
    scan_ctl.rd_en    = 1'b0;
    scan_ctl.rd_addr  = LEN_MAX_W'(idx);
    scan_ctl.job_done = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid && take_ok) begin
          q_ready = 1'b1;
          if (q_entry.job) begin
            start      = 1'b1;
            state_next = BK_SCAN;
          end else begin
            out_load    = 1'b1;
            out_pending = q_entry.pending;
          end
        end
      end
      BK_SCAN: begin
        scan_ctl.rd_en = !issue_done;
        if (issue_done && !rd_valid && take_ok) begin
          out_load          = 1'b1;
          out_pending       = 1'b0;
          out_done          = 1'b1;
          out_verdict       = verdict;
          out_length        = 6'(len);
          scan_ctl.job_done = 1'b1;
          state_next        = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= scan_ctl.rd_en;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx      <= '0;
      len      <= q_entry.len[AW-1:0];
      expected <= q_entry.expected;
      stop     <= 1'b0;
      fill     <= '0;
      found    <= '0;
    end else begin
      if (scan_ctl.rd_en) begin
        idx <= idx + AW'(1);
      end
      if (rd_valid && !stop) begin
        if (rd_data == 8'h00) begin
          stop <= 1'b1;
        end else begin
          win   <= win_next;
          fill  <= fill_next;
          found <= found | hit;
        end
      end
    end
    if (out_load) begin
      m_tdata <= {4'd0, out_length, out_verdict, out_done, out_pending};
    end
  end

endmodule

FILE: hw/rtl/modem_reply_line_classifier_top.sv
// Modem reply line classifier, top level.
// Each byte's result goes through a queue slot and then the result register; for a long
// line end the stored line is first scanned, one stored byte a cycle, then the verdict loaded.
// Throughput: one byte a cycle; input stalls while a line is scanned or the queue is full.
// Reset (rst, synchronous): line count, queue and result valid clear; store keeps old data.
// Depends on mrlc_pkg, mrlc_front, mrlc_fifo, mrlc_back.
module modem_reply_line_classifier_top
  import mrlc_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [1:0] expected_reply
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] reply_pending, [1] line_done, [5:2] verdict,
                                 // [11:6] line_length, [15:12] zero
);

  logic      fq_valid;
  logic      fq_ready;
  q_entry_t  fq_entry;
  logic      bq_valid;
  logic      bq_ready;
  q_entry_t  bq_entry;
  scan_ctl_t scan_ctl;
  logic [7:0] rd_data;
  logic      busy;

  mrlc_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_entry  (fq_entry),
    .scan_ctl (scan_ctl),
    .rd_data  (rd_data),
    .busy     (busy)
  );

  mrlc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_entry  (fq_entry),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_entry (bq_entry)
  );

  mrlc_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (bq_valid),
    .q_ready  (bq_ready),
    .q_entry  (bq_entry),
    .scan_ctl (scan_ctl),
    .rd_data  (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_done_when_busy: assert property (@(posedge clk) disable iff (rst)
    scan_ctl.job_done |-> busy)
    else $error("scan finished with no line held");

  a_read_when_busy: assert property (@(posedge clk) disable iff (rst)
    scan_ctl.rd_en |-> (busy && !s_tready))
    else $error("line store read while input open");

  a_verdict_with_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[5:2] != 4'd0 || m_tdata[11:6] != 6'd0)) |-> m_tdata[1])
    else $error("verdict or length without line_done");

  a_done_not_pending: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
    else $error("line_done with reply_pending set");

endmodule

FILE: tb/modem_reply_line_classifier_top_tb.sv
// Testbench for modem_reply_line_classifier_top: streams reply lines into the block
// and checks every per-byte reply against a predictor kept in a small scoreboard class.
// Depends on mrlc_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 1ps

module modem_reply_line_classifier_top_tb;
  import mrlc_pkg::*;

  localparam int LINE_BYTES = LINE_BYTES_DEF;
  localparam int RANDOM_ITEMS = 1320;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] EXP_NONE = 2'd0;
  localparam logic [1:0] EXP_SPARE = 2'd3;

  localparam string TXT_BUSY      = {"AT_BUSY", "_ERROR"};
  localparam string TXT_NO_NET    = {"AT_NO_NETWORK", "_JOINED"};
  localparam string TXT_CONFIRMED = {"+EVT:SEND", "_CONFIRMED"};
  localparam string TXT_PARAM     = {"AT_PARAM", "_ERROR"};

  typedef struct {
    logic       pending;
    logic       done;
    verdict_t   verdict;
    logic [5:0] len;
  } reply_t;

  class reply_checker;
    logic [7:0] store[LINE_BYTES];
    int unsigned fill;
    reply_t due[$];
    int errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function bit found(int tlen, string p);
      int plen;
      bit hit;
      plen = p.len();
      for (int s = 0; s + plen <= tlen; s++) begin
        hit = 1'b1;
        for (int k = 0; k < plen; k++) begin
          if (store[s + k] != p[k]) begin
            hit = 1'b0;
            break;
          end
        end
        if (hit) return 1'b1;
      end
      return 1'b0;
    endfunction

    function verdict_t classify(int len, logic [1:0] sel);
      int tlen;
      tlen = 0;
      while (tlen < len && store[tlen] != 8'h00) tlen++;
      if (sel == EXP_JOIN) begin
        if (found(tlen, "+EVT:JOIN FAILED")) return V_JOIN_FAILED;
        if (found(tlen, "+EVT:JOINED")) return V_JOINED;
        return V_JOIN_OTHER;
      end
      if (sel == EXP_SEND) begin
        if (found(tlen, TXT_BUSY)) return V_BUSY;
        if (found(tlen, TXT_NO_NET)) return V_NOT_JOINED;
        if (found(tlen, TXT_CONFIRMED)) return V_CONFIRMED;
        if (found(tlen, TXT_PARAM)) return V_PARAM_ERROR;
        return V_SEND_OTHER;
      end
      return V_NONE;
    endfunction

    function void take_byte(logic [7:0] b, logic [1:0] sel);
      reply_t r;
      r.pending = 1'b1;
      r.done = 1'b0;
      r.verdict = V_NONE;
      r.len = '0;
      if (b == BYTE_LF && fill > 0 && store[fill - 1] == BYTE_CR) begin
        if (fill > MIN_KEEP) begin
          r.len = 6'(fill - 1);
          r.pending = 1'b0;
          r.done = 1'b1;
          r.verdict = classify(fill - 1, sel);
        end
        fill = 0;
      end else if (fill < LINE_BYTES - 1) begin
        store[fill] = b;
        fill++;
      end else begin
        // store full: byte dropped, line restarts
        r.pending = 1'b0;
        fill = 0;
      end
      due.push_back(r);
    endfunction

    function void cmp(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0d, actual %0d", field, want, got);
      end
    endfunction

    function void check_reply(logic [15:0] d);
      reply_t w;
      if (due.size() == 0) begin
        errors++;
        $error("reply %h with no byte waiting", d);
        return;
      end
      w = due.pop_front();
      cmp("reply_pending", 16'(w.pending), 16'(d[0]));
      cmp("line_done", 16'(w.done), 16'(d[1]));
      cmp("verdict", 16'(w.verdict), 16'(d[5:2]));
      cmp("line_length", 16'(w.len), 16'(d[11:6]));
      cmp("padding", 16'd0, 16'(d[15:12]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  reply_checker board;
  logic [7:0] line_buf[$];
  int unsigned sent = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  string reply_texts[6] = '{"+EVT:JOIN FAILED", "+EVT:JOINED", TXT_BUSY,
                            TXT_NO_NET, TXT_CONFIRMED, TXT_PARAM};

  modem_reply_line_classifier_top #(.LINE_BYTES(LINE_BYTES)) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("modem_reply_line_classifier_top_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.take_byte(s_tdata, s_tuser);
    if (!rst && m_tvalid && m_tready) board.check_reply(m_tdata);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready = quiet || ($urandom_range(99) >= 32);
    end
  end

  task send_byte(input logic [7:0] b, input logic [1:0] sel);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 32) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tuser = sel;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // last byte carries the line's selector; others sometimes a random one
  task send_buf(input logic [1:0] sel, input bit mix_sel);
    for (int i = 0; i < line_buf.size(); i++) begin
      if (mix_sel && i < line_buf.size() - 1 && $urandom_range(99) < 10)
        send_byte(line_buf[i], 2'($urandom_range(3)));
      else
        send_byte(line_buf[i], sel);
    end
    line_buf.delete();
  endtask

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function void add_junk(int n);
    for (int i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(32, 126)));
  endfunction

  task send_line(input string s, input logic [1:0] sel);
    add_text(s);
    line_buf.push_back(BYTE_CR);
    line_buf.push_back(BYTE_LF);
    send_buf(sel, 1'b0);
  endtask

  task random_line();
    logic [1:0] sel;
    int r, idx, at;
    r = $urandom_range(99);
    sel = (r < 40) ? EXP_JOIN : (r < 80) ? EXP_SEND : (r < 90) ? EXP_NONE : EXP_SPARE;
    add_junk($urandom_range(8));
    if ($urandom_range(99) < 80) begin
      if (sel == EXP_JOIN && $urandom_range(9) < 8) idx = $urandom_range(1);
      else if (sel == EXP_SEND && $urandom_range(9) < 8) idx = $urandom_range(2, 5);
      else idx = $urandom_range(5);
      at = line_buf.size();
      add_text(reply_texts[idx]);
      r = $urandom_range(99);
      if (r < 10) void'(line_buf.pop_back());
      else if (r < 20) line_buf[at + $urandom_range(reply_texts[idx].len() - 1)] =
          8'($urandom_range(32, 126));
    end
    add_junk($urandom_range(8));
    if (line_buf.size() > 0 && $urandom_range(99) < 10)
      line_buf[$urandom_range(line_buf.size() - 1)] = 8'h00;
    while (line_buf.size() > 62) void'(line_buf.pop_back());
    line_buf.push_back(BYTE_CR);
    line_buf.push_back(BYTE_LF);
    send_buf(sel, 1'b1);
  endtask

  task random_noise();
    int r, n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      line_buf.push_back(r < 20 ? BYTE_CR : r < 40 ? BYTE_LF : 8'($urandom_range(255)));
    end
    send_buf(2'($urandom_range(3)), 1'b1);
  endtask

  initial begin
    int unsigned base, n;
    int r;
    bit held;
    board = new();
    held = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every verdict
    send_line("+EVT:JOIN FAILED", EXP_JOIN);
    send_line("+EVT:JOINED", EXP_JOIN);
    send_line("AT+JOIN=OK", EXP_JOIN);
    send_line(TXT_BUSY, EXP_SEND);
    send_line(TXT_NO_NET, EXP_SEND);
    send_line(TXT_CONFIRMED, EXP_SEND);
    send_line(TXT_PARAM, EXP_SEND);
    send_line("+EVT:TX_DONE", EXP_SEND);
    // priority: JOIN FAILED wins over a JOINED that comes earlier in the line
    send_line("+EVT:JOINED +EVT:JOIN FAILED", EXP_JOIN);
    // no reply expected, unused selector
    send_line(TXT_BUSY, EXP_NONE);
    send_line("+EVT:JOINED", EXP_SPARE);
    // short lines: 6+CR is dropped, 7+CR is the shortest classified
    send_line("OK", EXP_JOIN);
    send_line("ABCDEF", EXP_SEND);
    send_line("ABCDEFG", EXP_SEND);
    // LF without CR is stored
    line_buf.push_back(BYTE_LF);
    send_line({"AB\n", TXT_PARAM}, EXP_SEND);
    // zero byte cuts the searched text
    add_text("XY");
    line_buf.push_back(8'h00);
    send_line("+EVT:JOINED", EXP_JOIN);
    // extreme byte values
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    send_line("+EVT:JOINED", EXP_JOIN);
    // longest line
    add_junk(42);
    send_line(TXT_NO_NET, EXP_SEND);
    // overflow, then a normal line
    add_junk(70);
    send_buf(EXP_JOIN, 1'b0);
    send_line("+EVT:JOIN FAILED", EXP_JOIN);
    send_line("CRCR\r\r", EXP_JOIN);

    base = sent;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (!held && n >= 400) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      quiet = (n >= 800 && n < 1100);
      r = $urandom_range(99);
      if (r < 72) random_line();
      else if (r < 80) begin
        add_junk($urandom_range(6));
        line_buf.push_back(BYTE_CR);
        line_buf.push_back(BYTE_LF);
        send_buf(2'($urandom_range(3)), 1'b1);
      end else if (r < 87) begin
        add_junk($urandom_range(63, 90));
        line_buf.push_back(BYTE_CR);
        line_buf.push_back(BYTE_LF);
        send_buf(2'($urandom_range(3)), 1'b1);
      end else random_noise();
      n = sent - base;
    end
    quiet = 1'b0;
    @(negedge clk);
    s_tvalid = 1'b0;

    while (board.due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("modem_reply_line_classifier_top_tb passed");
    else $display("modem_reply_line_classifier_top_tb failed");
    $finish;
  end

endmodule
